/* rtl/core/stti_pkg.sv */
package stti_pkg;

  // Field widths of the stream words.
  localparam int BrickW    = 24;
  localparam int ChildW    = 24;
  localparam int TimeIdxW  = 25;
  localparam int LevelW    = 3;
  localparam int TimeLvlW  = 4;
  localparam int NodesW    = 16;
  localparam int TnodeW    = 8;
  localparam int OutDataW  = 112;

  // Largest supported tree shape.
  localparam logic [LevelW-1:0]   MAX_OCTREE_LEVELS = 3'd6;
  localparam logic [TimeLvlW-1:0] MAX_TIME_LEVELS   = 4'd8;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_OCTREE_LEVELS = 1'b0,
    CFG_TIME_LEVELS   = 1'b1
  } cfg_idx_t;

  // Shape values derived from the configuration registers.
  typedef struct packed {
    logic [LevelW-1:0]   oct_levels;  // clamped octree level count
    logic [TimeLvlW-1:0] time_levels; // clamped time level count
    logic [NodesW-1:0]   nodes;       // octree size N
    logic [BrickW-1:0]   total;       // N times the number of time nodes
    logic [TnodeW-1:0]   half;        // first time node on the last time level
  } cfg_t;

  // Number of nodes in the first d levels of an octree.
  function automatic logic [NodesW-1:0] octree_prefix(input logic [LevelW-1:0] d);
    logic [NodesW-1:0] p;
    case (d)
      3'd0:    p = 16'd0;
      3'd1:    p = 16'd1;
      3'd2:    p = 16'd9;
      3'd3:    p = 16'd73;
      3'd4:    p = 16'd585;
      3'd5:    p = 16'd4681;
      3'd6:    p = 16'd37449;
      default: p = 16'd37449;
    endcase
    return p;
  endfunction

endpackage

/* rtl/core/stti_cfg.sv */
module stti_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [stti_pkg::TimeLvlW-1:0] cfg_wdata,
  output stti_pkg::cfg_t                cfg
);
  import stti_pkg::*;

  logic [LevelW-1:0]     oct_raw;
  logic [TimeLvlW-1:0]   time_raw;
  logic [LevelW-1:0]     oct_nxt;
  logic [TimeLvlW-1:0]   time_nxt;
  logic [TnodeW-1:0]     tnodes_nxt;
  logic [NodesW-1:0]     nodes_nxt;
  logic [NodesW+TnodeW-1:0] prod_nxt;
  cfg_t                  cfg_r;
  cfg_t                  cfg_nxt;

  // Pick the value each register will hold after this edge.
  always_comb begin
    oct_raw  = cfg_r.oct_levels;
    time_raw = cfg_r.time_levels;
    if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_OCTREE_LEVELS)) begin
      oct_raw = cfg_wdata[LevelW-1:0];
    end
    if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_TIME_LEVELS)) begin
      time_raw = cfg_wdata;
    end
  end

  // Clamp to the supported range and derive the tree shape.
  always_comb begin
    if (oct_raw == '0) begin
      oct_nxt = 3'd1;
    end else if (oct_raw > MAX_OCTREE_LEVELS) begin
      oct_nxt = MAX_OCTREE_LEVELS;
    end else begin
      oct_nxt = oct_raw;
    end
    if (time_raw == '0) begin
      time_nxt = 4'd1;
    end else if (time_raw > MAX_TIME_LEVELS) begin
      time_nxt = MAX_TIME_LEVELS;
    end else begin
      time_nxt = time_raw;
    end
    nodes_nxt  = octree_prefix(oct_nxt);
    tnodes_nxt = TnodeW'((9'd1 << time_nxt) - 9'd1);
    prod_nxt   = nodes_nxt * tnodes_nxt;
    cfg_nxt.oct_levels  = oct_nxt;
    cfg_nxt.time_levels = time_nxt;
    cfg_nxt.nodes       = nodes_nxt;
    cfg_nxt.total       = BrickW'(prod_nxt);
    cfg_nxt.half        = tnodes_nxt >> 1;
  end

  // Shape registers; reset gives four octree levels and four time levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oct_levels  <= 3'd4;
      cfg_r.time_levels <= 4'd4;
      cfg_r.nodes       <= 16'd585;
      cfg_r.total       <= 24'd8775;
      cfg_r.half        <= 8'd7;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/space_time_tree_node_index.sv */
// Node index unit for a space-time tree: a complete binary time tree whose
// every node holds a complete octree of N nodes, stored node-major.
// The in_ stream carries one brick index per word. The out_ stream returns
// one word per input word, in order, with the octree child, both time
// children, the leaf flags, the level numbers and the child-table entry;
// out_tuser is the in-range flag, and an index past the tree gives an all
// zero out_tdata.
// Throughput is one word per clock while the receiver does not stall. Three
// register stages of restoring division steps (quotient of eight bits,
// divisor N; the first also does the range compare) feed the output
// register, which forms the children with adds only.
// The cfg_ port writes the octree and time level counts; the derived shape
// is registered at the write edge, so a word may follow on the next clock.
// Reset (synchronous, rst_n low) empties the pipeline and sets four octree
// levels and four time levels.
// When the receiver stalls, each stage holds its word while stages behind a
// bubble keep moving; in_tready drops only once every stage is full.
module space_time_tree_node_index (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // node_index
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // octree_child[23:0], time_left[48:24], time_right[73:49], time_leaf[74],
  // octree_leaf[75], spatial_level[78:76], temporal_level[81:79],
  // child_entry[106:82], zero fill[111:107]
  output logic [stti_pkg::OutDataW-1:0] out_tdata,
  output logic                          out_tuser,  // in_range
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [stti_pkg::TimeLvlW-1:0] cfg_wdata
);
  import stti_pkg::*;

  cfg_t cfg;

  stti_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stage handshake: a stage takes a word when it is empty or drains.
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out   = !out_valid_r || out_tready;
  assign rdy3      = !s3_valid_r || rdy_out;
  assign rdy2      = !s2_valid_r || rdy3;
  assign rdy1      = !s1_valid_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    s1_valid_r  <= in_tvalid;
      if (rdy2)    s2_valid_r  <= s1_valid_r;
      if (rdy3)    s3_valid_r  <= s2_valid_r;
      if (rdy_out) out_valid_r <= s3_valid_r;
    end
  end

  // Stage 1: range check and quotient bits 7 and 6.
  logic [BrickW-1:0] s1_idx_r, s1_rem_r, s1_rem_nxt, s1_sh;
  logic [TnodeW-1:0] s1_q_r, s1_q_nxt;
  logic              s1_rng_r;

  always_comb begin
    s1_rem_nxt = in_tdata;
    s1_q_nxt   = '0;
    s1_sh      = '0;
    for (int b = 7; b >= 6; b--) begin
      s1_sh = BrickW'(cfg.nodes) << b;
      if (s1_rem_nxt >= s1_sh) begin
        s1_rem_nxt = s1_rem_nxt - s1_sh;
        s1_q_nxt[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_idx_r <= in_tdata;
      s1_rem_r <= s1_rem_nxt;
      s1_q_r   <= s1_q_nxt;
      s1_rng_r <= (in_tdata < cfg.total);
    end
  end

  // Stage 2: quotient bits 5 to 3.
  logic [BrickW-1:0] s2_idx_r, s2_rem_r, s2_rem_nxt, s2_sh;
  logic [TnodeW-1:0] s2_q_r, s2_q_nxt;
  logic              s2_rng_r;

  always_comb begin
    s2_rem_nxt = s1_rem_r;
    s2_q_nxt   = s1_q_r;
    s2_sh      = '0;
    for (int b = 5; b >= 3; b--) begin
      s2_sh = BrickW'(cfg.nodes) << b;
      if (s2_rem_nxt >= s2_sh) begin
        s2_rem_nxt = s2_rem_nxt - s2_sh;
        s2_q_nxt[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_idx_r <= s1_idx_r;
      s2_rem_r <= s2_rem_nxt;
      s2_q_r   <= s2_q_nxt;
      s2_rng_r <= s1_rng_r;
    end
  end

  // Stage 3: quotient bits 2 to 0; the remainder is the octree node.
  logic [BrickW-1:0] s3_idx_r, s3_rem_nxt, s3_sh;
  logic [NodesW-1:0] s3_onode_r;
  logic [TnodeW-1:0] s3_tnode_r, s3_q_nxt;
  logic              s3_rng_r;

  always_comb begin
    s3_rem_nxt = s2_rem_r;
    s3_q_nxt   = s2_q_r;
    s3_sh      = '0;
    for (int b = 2; b >= 0; b--) begin
      s3_sh = BrickW'(cfg.nodes) << b;
      if (s3_rem_nxt >= s3_sh) begin
        s3_rem_nxt = s3_rem_nxt - s3_sh;
        s3_q_nxt[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_idx_r   <= s2_idx_r;
      s3_onode_r <= s3_rem_nxt[NodesW-1:0];
      s3_tnode_r <= s3_q_nxt;
      s3_rng_r   <= s2_rng_r;
    end
  end

  // Output stage: depths and child indexes. With idx = t*N + o,
  // the octree child is idx + 7*o + 1 and the left time child 2*idx - o + N.
  logic [LevelW-1:0]   odepth;
  logic [ChildW-1:0]   child_nxt;
  logic [TimeIdxW:0]   left_wide;
  logic [TimeIdxW-1:0] left_nxt, right_nxt;
  logic                tleaf_nxt, oleaf_nxt;
  logic [LevelW-1:0]   slvl_nxt, tlvl_nxt;
  logic [TimeIdxW-1:0] entry_nxt;
  logic [TimeLvlW-1:0] tdepth_w;

  always_comb begin
    odepth = '0;
    for (int d = 1; d <= 5; d++) begin
      if ((LevelW'(d) < cfg.oct_levels) &&
          (octree_prefix(LevelW'(d)) <= s3_onode_r)) begin
        odepth = LevelW'(d);
      end
    end
    tdepth_w = '0;
    for (int d = 1; d <= 7; d++) begin
      if ((TimeLvlW'(d) < cfg.time_levels) &&
          (TnodeW'((9'd1 << d) - 9'd1) <= s3_tnode_r)) begin
        tdepth_w = TimeLvlW'(d);
      end
    end
    child_nxt = s3_idx_r + ChildW'({s3_onode_r, 3'b000}) - ChildW'(s3_onode_r) + 24'd1;
    left_wide = {1'b0, s3_idx_r, 1'b0} - (TimeIdxW+1)'(s3_onode_r)
              + (TimeIdxW+1)'(cfg.nodes);
    left_nxt  = left_wide[TimeIdxW-1:0];
    right_nxt = left_nxt + TimeIdxW'(cfg.nodes);
    tleaf_nxt = (s3_tnode_r >= cfg.half);
    oleaf_nxt = (odepth == cfg.oct_levels - 3'd1);
    slvl_nxt  = cfg.oct_levels - 3'd1 - odepth;
    tlvl_nxt  = LevelW'(cfg.time_levels - 4'd1 - tdepth_w);
    if (s3_tnode_r == '0) begin
      entry_nxt = oleaf_nxt ? '1 : TimeIdxW'(child_nxt);
    end else begin
      entry_nxt = tleaf_nxt ? '1 : left_nxt;
    end
  end

  logic [ChildW-1:0]   child_r;
  logic [TimeIdxW-1:0] left_r, right_r, entry_r;
  logic                tleaf_r, oleaf_r, rng_r;
  logic [LevelW-1:0]   slvl_r, tlvl_r;

  // Output register; an out-of-range index clears every field.
  always_ff @(posedge clk) begin
    if (rdy_out) begin
      rng_r   <= s3_rng_r;
      child_r <= s3_rng_r ? child_nxt : '0;
      left_r  <= s3_rng_r ? left_nxt  : '0;
      right_r <= s3_rng_r ? right_nxt : '0;
      tleaf_r <= s3_rng_r && tleaf_nxt;
      oleaf_r <= s3_rng_r && oleaf_nxt;
      slvl_r  <= s3_rng_r ? slvl_nxt  : '0;
      tlvl_r  <= s3_rng_r ? tlvl_nxt  : '0;
      entry_r <= s3_rng_r ? entry_nxt : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = rng_r;
  assign out_tdata  = {5'b00000, entry_r, tlvl_r, slvl_r, oleaf_r, tleaf_r,
                       right_r, left_r, child_r};

  // An index past the tree leaves every data field at zero.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !rng_r |-> out_tdata == '0)
    else $error("out-of-range word carries nonzero fields");

  // The right time child sits exactly one octree past the left one.
  a_right_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rng_r |-> (right_r - left_r) == TimeIdxW'(cfg.nodes))
    else $error("time_right is not time_left plus N");

  // A node that is a leaf in both trees has no child-table entry.
  a_leaf_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rng_r && tleaf_r && oleaf_r |-> entry_r == '1)
    else $error("leaf node has a child-table entry");

  // A word in the last division stage is held while the output stalls.
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !rdy_out |=> s3_valid_r && $stable(s3_idx_r))
    else $error("division stage lost a word under stall");

endmodule
